@@ design/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 28;
   localparam int unsigned LEN_W   = 32;
   localparam int unsigned VLQCNT_W = 2;

   localparam logic [3:0] META_NIBBLE = 4'hF;

   typedef enum logic [2:0] {
      PH_DELTA  = 3'd0,
      PH_STATUS = 3'd1,
      PH_PARAM1 = 3'd2,
      PH_PARAM2 = 3'd3,
      PH_MTYPE  = 3'd4,
      PH_MLEN   = 3'd5,
      PH_MDATA  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHANNEL = 2'd0,
      KIND_META_HDR = 2'd1,
      KIND_META_DATA = 2'd2
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] track_byte;
      logic              track_start;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [VALUE_W-1:0] delta_time;
      logic [3:0]         event_type;
      logic [3:0]         channel;
      logic [BYTE_W-1:0]  param_one;
      logic [BYTE_W-1:0]  param_two;
      logic [VALUE_W-1:0] meta_length;
      logic [BYTE_W-1:0]  data_byte;
      logic               last_of_event;
      logic               track_done;
      logic               overrun;
   } rsp_type;

endpackage

@@ design/midi_track_event_parser_core.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser_core
// Byte-at-a-time parser for the event stream of a MIDI file track.
// ----------------------------------------------------------------------------
// Takes one track byte per request and returns at most one result per request:
// a channel event on its second parameter byte, a meta header once the meta
// length is complete, and one result per meta data byte. Every request is
// handled combinationally between the request handshake and the result
// register, so one byte per clock is sustained while the result is not stalled;
// a new request is taken while the result register is empty or being
// drained the same cycle. Bytes past csr track length return an overrun
// result. csr_wr_data must be written only while no result is pending.
module midi_track_event_parser_core
   import mtep_pkg::*;
#(
   parameter int unsigned VLQ_MAX_BYTES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam logic [VLQCNT_W:0] VLQ_LIMIT = (VLQCNT_W+1)'(VLQ_MAX_BYTES);

   phase_type             phase_ff,    phase_in;
   logic [VALUE_W-1:0]    delta_ff,    delta_in;
   logic [VLQCNT_W-1:0]   vlq_cnt_ff,  vlq_cnt_in;
   logic [BYTE_W-1:0]     status_ff,   status_in;
   logic [BYTE_W-1:0]     param_ff,    param_in;
   logic [VALUE_W-1:0]    meta_rem_ff, meta_rem_in;
   logic [LEN_W-1:0]      pos_ff,      pos_in;
   logic [LEN_W-1:0]      len_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff,       rsp_in;

   phase_type             phase_b;
   logic [VALUE_W-1:0]    delta_b, meta_b, vlq_src, vlq_acc;
   logic [VLQCNT_W-1:0]   cnt_b, cnt_use;
   logic [BYTE_W-1:0]     status_b, param_b, tbyte;
   logic [LEN_W-1:0]      pos_b;
   logic                  accept, emit, vlq_end;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign tbyte     = req_data.track_byte;

   always_comb begin
      phase_b  = req_data.track_start ? PH_DELTA : phase_ff;
      delta_b  = req_data.track_start ? '0 : delta_ff;
      cnt_b    = req_data.track_start ? '0 : vlq_cnt_ff;
      status_b = req_data.track_start ? '0 : status_ff;
      param_b  = req_data.track_start ? '0 : param_ff;
      meta_b   = req_data.track_start ? '0 : meta_rem_ff;
      pos_b    = req_data.track_start ? '0 : pos_ff;

      cnt_use  = (phase_b == PH_DELTA || phase_b == PH_MLEN) ? cnt_b : '0;
      if (phase_b == PH_MLEN) begin
         vlq_src = meta_b;
      end else if (phase_b != PH_DELTA || cnt_b == '0) begin
         vlq_src = '0;
      end else begin
         vlq_src = delta_b;
      end
      vlq_acc = {vlq_src[VALUE_W-8:0], tbyte[6:0]};
      vlq_end = ~tbyte[7] | (({1'b0, cnt_use} + 1'b1) >= VLQ_LIMIT);
   end

   always_comb begin
      phase_in     = phase_ff;
      delta_in     = delta_ff;
      vlq_cnt_in   = vlq_cnt_ff;
      status_in    = status_ff;
      param_in     = param_ff;
      meta_rem_in  = meta_rem_ff;
      pos_in       = pos_ff;
      emit         = 1'b0;
      rsp_in       = '0;

      if (accept) begin
         phase_in    = phase_b;
         delta_in    = delta_b;
         vlq_cnt_in  = cnt_b;
         status_in   = status_b;
         param_in    = param_b;
         meta_rem_in = meta_b;
         pos_in      = pos_b;

         if (pos_b >= len_ff) begin
            emit              = 1'b1;
            rsp_in.track_done = 1'b1;
            rsp_in.overrun    = 1'b1;
         end else begin
            pos_in = pos_b + 1'b1;
            unique case (phase_b)
               PH_STATUS: begin
                  status_in = tbyte;
                  phase_in  = (tbyte[7:4] == META_NIBBLE) ? PH_MTYPE : PH_PARAM1;
               end
               PH_PARAM1: begin
                  param_in = tbyte;
                  phase_in = PH_PARAM2;
               end
               PH_PARAM2: begin
                  emit                 = 1'b1;
                  rsp_in.result_kind   = KIND_CHANNEL;
                  rsp_in.param_one     = param_b;
                  rsp_in.param_two     = tbyte;
                  rsp_in.last_of_event = 1'b1;
                  phase_in             = PH_DELTA;
               end
               PH_MTYPE: begin
                  param_in    = tbyte;
                  meta_rem_in = '0;
                  vlq_cnt_in  = '0;
                  phase_in    = PH_MLEN;
               end
               PH_MLEN: begin
                  meta_rem_in = vlq_acc;
                  vlq_cnt_in  = vlq_end ? '0 : cnt_use + 1'b1;
                  if (vlq_end) begin
                     emit                 = 1'b1;
                     rsp_in.result_kind   = KIND_META_HDR;
                     rsp_in.param_one     = param_b;
                     rsp_in.meta_length   = vlq_acc;
                     rsp_in.last_of_event = (vlq_acc == '0);
                     phase_in             = (vlq_acc == '0) ? PH_DELTA : PH_MDATA;
                  end
               end
               PH_MDATA: begin
                  emit                 = 1'b1;
                  rsp_in.result_kind   = KIND_META_DATA;
                  rsp_in.param_one     = param_b;
                  rsp_in.data_byte     = tbyte;
                  meta_rem_in          = meta_b - 1'b1;
                  rsp_in.last_of_event = (meta_b == VALUE_W'(1));
                  if (meta_b == VALUE_W'(1)) begin
                     phase_in = PH_DELTA;
                  end
               end
               default: begin
                  delta_in   = vlq_acc;
                  vlq_cnt_in = vlq_end ? '0 : cnt_use + 1'b1;
                  phase_in   = vlq_end ? PH_STATUS : PH_DELTA;
               end
            endcase
            rsp_in.delta_time = delta_in;
            rsp_in.event_type = status_in[7:4];
            rsp_in.channel    = status_in[3:0];
            rsp_in.track_done = (pos_in == len_ff);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         delta_ff     <= '0;
         vlq_cnt_ff   <= '0;
         status_ff    <= '0;
         param_ff     <= '0;
         meta_rem_ff  <= '0;
         pos_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         delta_ff     <= delta_in;
         vlq_cnt_ff   <= vlq_cnt_in;
         status_ff    <= status_in;
         param_ff     <= param_in;
         meta_rem_ff  <= meta_rem_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   a_overrun_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overrun |-> rsp_data.track_done)
      else $error("overrun result without track_done");

   a_exhausted_overrun : assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.track_start && (pos_ff >= len_ff)
      |=> rsp_valid && rsp_data.overrun)
      else $error("byte past track end not flagged");

   a_mdata_nonzero : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MDATA) |-> (meta_rem_ff != '0))
      else $error("meta data phase with nothing remaining");

   a_vlq_bound : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, vlq_cnt_ff} < VLQ_LIMIT))
      else $error("quantity byte count past limit");

endmodule
